@@ rtl/lfysb_pkg.sv @@
// Shared constants, request codes and controller/datapath interface types for the shuffle bag.
package lfysb_pkg;

    // Bag geometry.
    localparam int BAG_DEPTH = 128;
    localparam int ADDR_W    = $clog2(BAG_DEPTH);
    localparam int CNT_W     = $clog2(BAG_DEPTH + 1);

    // Field widths.
    localparam int ITEM_W = 8;
    localparam int REQ_W  = 2;
    localparam int GEN_W  = 32;
    localparam int RND_W  = 16;

    // Generator constants.
    localparam logic [GEN_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [GEN_W-1:0] LCG_ADD = 32'd1013904223;

    // Remainder unit retires one dividend bit per cycle.
    localparam int DIV_STEPS = RND_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SHUFFLE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DRAW    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic push;
        logic set_ovf;
        logic set_empty;
        logic seed_load;
        logic gen_step;
        logic div_step;
        logic rd_i;
        logic rd_j;
        logic wr_i;
        logic wr_j;
        logic draw_rd;
        logic draw_take;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             empty;
        logic             lt2;
        logic             div_done;
        logic             idx_last;
        logic             out_free;
    } t_sts;

endpackage

@@ rtl/lfysb_dp.sv @@
// Datapath of the shuffle bag: item RAM, fill count, generator, remainder unit and result register.
module lfysb_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lfysb_pkg::REQ_W-1:0]       i_req_type,
    input  logic [lfysb_pkg::ITEM_W-1:0]      i_item_value,
    input  logic                              i_seed_we,
    input  logic [lfysb_pkg::GEN_W-1:0]       i_seed_wdata,
    input  logic                              i_stall,
    input  lfysb_pkg::t_cmd                   i_cmd,
    output lfysb_pkg::t_sts                   o_sts,
    output logic                              o_valid,
    output logic [lfysb_pkg::ITEM_W-1:0]      o_drawn_item,
    output logic                              o_bag_empty,
    output logic                              o_push_overflow,
    output logic [lfysb_pkg::CNT_W-1:0]       o_items_left
);

    // Item RAM with one write port and one registered read port.
    logic [lfysb_pkg::ITEM_W-1:0] r_mem [lfysb_pkg::BAG_DEPTH];
    logic [lfysb_pkg::ITEM_W-1:0] r_rd_data;
    logic [lfysb_pkg::ITEM_W-1:0] r_tmp;

    logic [lfysb_pkg::REQ_W-1:0]  r_req;
    logic [lfysb_pkg::ITEM_W-1:0] r_item;
    logic [lfysb_pkg::CNT_W-1:0]  r_count;
    logic [lfysb_pkg::GEN_W-1:0]  r_seed;
    logic [lfysb_pkg::GEN_W-1:0]  r_gen;
    logic [lfysb_pkg::GEN_W-1:0]  n_gen;
    logic [lfysb_pkg::ADDR_W-1:0] r_idx;

    logic [lfysb_pkg::RND_W-1:0]  r_dvd;
    logic [lfysb_pkg::CNT_W-1:0]  r_rem;
    logic [lfysb_pkg::CNT_W-1:0]  n_rem;
    logic [lfysb_pkg::DIV_CW-1:0] r_div_cnt;
    logic [lfysb_pkg::CNT_W-1:0]  divisor;
    logic [lfysb_pkg::CNT_W:0]    trial;

    logic [lfysb_pkg::ITEM_W-1:0] r_res_drawn;
    logic                         r_res_empty;
    logic                         r_res_ovf;

    logic [lfysb_pkg::ITEM_W-1:0] r_out_drawn;
    logic                         r_out_empty;
    logic                         r_out_ovf;
    logic [lfysb_pkg::CNT_W-1:0]  r_out_left;
    logic                         r_out_valid;

    logic [lfysb_pkg::ADDR_W-1:0] top_addr;
    logic [lfysb_pkg::ADDR_W-1:0] j_addr;
    logic [lfysb_pkg::ADDR_W-1:0] rd_addr;
    logic [lfysb_pkg::ADDR_W-1:0] wr_addr;
    logic [lfysb_pkg::ITEM_W-1:0] wr_data;
    logic                         wr_en;

    // Address of the top item and the swap partner taken from the remainder.
    assign top_addr = lfysb_pkg::ADDR_W'(r_count - lfysb_pkg::CNT_W'(1));
    assign j_addr   = r_rem[lfysb_pkg::ADDR_W-1:0];

    // RAM port selection.
    always_comb begin
        rd_addr = r_idx;
        if (i_cmd.rd_j) begin
            rd_addr = j_addr;
        end else if (i_cmd.draw_rd) begin
            rd_addr = top_addr;
        end
        wr_en   = i_cmd.push | i_cmd.wr_i | i_cmd.wr_j;
        wr_addr = r_idx;
        wr_data = r_rd_data;
        if (i_cmd.push) begin
            wr_addr = r_count[lfysb_pkg::ADDR_W-1:0];
            wr_data = r_item;
        end else if (i_cmd.wr_j) begin
            wr_addr = j_addr;
            wr_data = r_tmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        // The read register loads only on a read command and holds through the writes.
        if (i_cmd.rd_i | i_cmd.rd_j | i_cmd.draw_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
        // The first read of a swap is kept while the partner is fetched.
        if (i_cmd.rd_j) begin
            r_tmp <= r_rd_data;
        end
    end

    // Generator advance: low 32 bits of the product plus the increment.
    assign n_gen = r_gen * lfysb_pkg::LCG_MUL + lfysb_pkg::LCG_ADD;

    // One restoring remainder step against the divisor i + 1.
    assign divisor = lfysb_pkg::CNT_W'(r_idx) + lfysb_pkg::CNT_W'(1);
    assign trial   = {r_rem, r_dvd[lfysb_pkg::RND_W-1]};
    assign n_rem   = (trial >= {1'b0, divisor}) ?
                     lfysb_pkg::CNT_W'(trial - {1'b0, divisor}) :
                     trial[lfysb_pkg::CNT_W-1:0];

    // Control registers: count, seed, generator and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_seed      <= lfysb_pkg::GEN_W'(1);
            r_gen       <= lfysb_pkg::GEN_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_seed_we) begin
                r_seed <= i_seed_wdata;
            end
            if (i_cmd.push) begin
                r_count <= r_count + lfysb_pkg::CNT_W'(1);
            end else if (i_cmd.draw_rd) begin
                r_count <= r_count - lfysb_pkg::CNT_W'(1);
            end
            if (i_cmd.seed_load) begin
                r_gen <= (r_seed == '0) ? lfysb_pkg::GEN_W'(1) : r_seed;
            end else if (i_cmd.gen_step) begin
                r_gen <= n_gen;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, walk index, remainder unit and result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req       <= i_req_type;
            r_item      <= i_item_value;
            r_res_drawn <= '0;
            r_res_empty <= 1'b0;
            r_res_ovf   <= 1'b0;
        end
        if (i_cmd.set_ovf) begin
            r_res_ovf <= 1'b1;
        end
        if (i_cmd.set_empty) begin
            r_res_empty <= 1'b1;
        end
        if (i_cmd.draw_take) begin
            r_res_drawn <= r_rd_data;
        end
        if (i_cmd.seed_load) begin
            r_idx <= top_addr;
        end else if (i_cmd.wr_j) begin
            r_idx <= r_idx - lfysb_pkg::ADDR_W'(1);
        end
        // Division starts on the freshly advanced generator value.
        if (i_cmd.gen_step) begin
            r_dvd     <= n_gen[lfysb_pkg::GEN_W-1 -: lfysb_pkg::RND_W];
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd     <= {r_dvd[lfysb_pkg::RND_W-2:0], 1'b0};
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt + lfysb_pkg::DIV_CW'(1);
        end
        if (i_cmd.out_load) begin
            r_out_drawn <= r_res_drawn;
            r_out_empty <= r_res_empty;
            r_out_ovf   <= r_res_ovf;
            r_out_left  <= r_count;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts.req      = r_req;
        o_sts.full     = (r_count == lfysb_pkg::CNT_W'(lfysb_pkg::BAG_DEPTH));
        o_sts.empty    = (r_count == '0);
        o_sts.lt2      = (r_count < lfysb_pkg::CNT_W'(2));
        o_sts.div_done = (r_div_cnt == lfysb_pkg::DIV_CW'(lfysb_pkg::DIV_STEPS - 1));
        o_sts.idx_last = (r_idx == lfysb_pkg::ADDR_W'(1));
        o_sts.out_free = !r_out_valid || !i_stall;
    end

    assign o_valid         = r_out_valid;
    assign o_drawn_item    = r_out_drawn;
    assign o_bag_empty     = r_out_empty;
    assign o_push_overflow = r_out_ovf;
    assign o_items_left    = r_out_left;

endmodule

@@ rtl/lfysb_ctrl.sv @@
// Controller state machine that sequences push, draw and the shuffle walk.
module lfysb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  lfysb_pkg::t_sts i_sts,
    output lfysb_pkg::t_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DECODE  = 4'd1;
    localparam logic [3:0] ST_SH_GEN  = 4'd2;
    localparam logic [3:0] ST_SH_DIV  = 4'd3;
    localparam logic [3:0] ST_SH_RDI  = 4'd4;
    localparam logic [3:0] ST_SH_RDJ  = 4'd5;
    localparam logic [3:0] ST_SH_WRI  = 4'd6;
    localparam logic [3:0] ST_SH_WRJ  = 4'd7;
    localparam logic [3:0] ST_DR_WAIT = 4'd8;
    localparam logic [3:0] ST_FINISH  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_FINISH;
                unique case (i_sts.req)
                    lfysb_pkg::REQ_PUSH: begin
                        o_cmd.push    = !i_sts.full;
                        o_cmd.set_ovf = i_sts.full;
                    end
                    lfysb_pkg::REQ_SHUFFLE: begin
                        o_cmd.seed_load = 1'b1;
                        if (!i_sts.lt2) begin
                            n_state = ST_SH_GEN;
                        end
                    end
                    lfysb_pkg::REQ_DRAW: begin
                        o_cmd.set_empty = i_sts.empty;
                        o_cmd.draw_rd   = !i_sts.empty;
                        if (!i_sts.empty) begin
                            n_state = ST_DR_WAIT;
                        end
                    end
                    lfysb_pkg::REQ_NOP: begin
                        n_state = ST_FINISH;
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_SH_GEN: begin
                o_cmd.gen_step = 1'b1;
                n_state        = ST_SH_DIV;
            end
            ST_SH_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_SH_RDI;
                end
            end
            ST_SH_RDI: begin
                o_cmd.rd_i = 1'b1;
                n_state    = ST_SH_RDJ;
            end
            ST_SH_RDJ: begin
                o_cmd.rd_j = 1'b1;
                n_state    = ST_SH_WRI;
            end
            ST_SH_WRI: begin
                o_cmd.wr_i = 1'b1;
                n_state    = ST_SH_WRJ;
            end
            ST_SH_WRJ: begin
                // Swap done; index 1 is the last step of the walk.
                o_cmd.wr_j = 1'b1;
                n_state    = i_sts.idx_last ? ST_FINISH : ST_SH_GEN;
            end
            ST_DR_WAIT: begin
                o_cmd.draw_take = 1'b1;
                n_state         = ST_FINISH;
            end
            ST_FINISH: begin
                // Hold the result until the output register can take it.
                o_cmd.out_load = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

@@ rtl/lcg_fisher_yates_shuffle_bag_unit.sv @@
// Top level of the shuffle bag: controller, datapath and interface checks.
// A shuffle walks the index from the top item down to one; per step the generator
// advances, the bit-serial remainder unit runs and the swap uses the single RAM port.
// One word is in flight at a time; a finished result waits in the output register.
// Synchronous active-low reset empties the bag and sets seed and generator to one.
module lcg_fisher_yates_shuffle_bag_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [lfysb_pkg::REQ_W-1:0]       i_req_type,
    input  logic [lfysb_pkg::ITEM_W-1:0]      i_item_value,
    input  logic                              i_seed_we,
    input  logic [lfysb_pkg::GEN_W-1:0]       i_seed_wdata,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [lfysb_pkg::ITEM_W-1:0]      o_drawn_item,
    output logic                              o_bag_empty,
    output logic                              o_push_overflow,
    output logic [lfysb_pkg::CNT_W-1:0]       o_items_left
);

    lfysb_pkg::t_cmd cmd;
    lfysb_pkg::t_sts sts;

    lfysb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lfysb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_type      (i_req_type),
        .i_item_value    (i_item_value),
        .i_seed_we       (i_seed_we),
        .i_seed_wdata    (i_seed_wdata),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_drawn_item    (o_drawn_item),
        .o_bag_empty     (o_bag_empty),
        .o_push_overflow (o_push_overflow),
        .o_items_left    (o_items_left)
    );

    // The reported count never exceeds the bag size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_items_left <= lfysb_pkg::CNT_W'(lfysb_pkg::BAG_DEPTH)))
        else $error("items_left beyond bag size");

    // An empty draw returns no item and leaves the bag at zero.
    a_empty_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bag_empty) |-> (o_drawn_item == '0 && o_items_left == '0))
        else $error("empty draw with item or nonzero count");

    // A refused push only happens on a full bag and never with an empty flag.
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_push_overflow) |->
        (o_items_left == lfysb_pkg::CNT_W'(lfysb_pkg::BAG_DEPTH) && !o_bag_empty))
        else $error("overflow flag with bag not full");

    // A new result only appears while the block is still busy with its word.
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load) |-> o_stall)
        else $error("result loaded while idle");

endmodule
